[design/frame_budget_window_monitor_macros.svh]
// Assertion macros used by the frame budget window monitor sequencer.
`ifndef FRAME_BUDGET_WINDOW_MONITOR_MACROS_SVH
`define FRAME_BUDGET_WINDOW_MONITOR_MACROS_SVH
`ifndef SYNTHESIS
`define FBWM_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fbwm assertion failed");
`define FBWM_ASSERT_NEXT(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("fbwm assertion failed");
`else
`define FBWM_ASSERT(name, clk, rst, prop)
`define FBWM_ASSERT_NEXT(name, clk, rst, a, b)
`endif
`endif

[design/fbwm_pkg.sv]
// Types and constants of the frame budget window monitor.
package fbwm_pkg;
  localparam int TW  = 23;
  localparam int IW  = 24;
  localparam int CW  = 32;
  localparam int BW  = 5;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_WARN   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_CRIT   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_RENDER = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_SIM    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_STREAM = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_ALLOC  = 3'd6;

  localparam logic [TW-1:0] ONE_MS = 23'd256;
  localparam int RECIP_20 = 3277;
  localparam int RECIP_SH = 16;

  localparam logic [1:0] HEALTH_GOOD = 2'd0;
  localparam logic [1:0] HEALTH_WARN = 2'd1;
  localparam logic [1:0] HEALTH_CRIT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_INIT, S_SCAN, S_DRAIN, S_STEP, S_DIV_INIT, S_DIV, S_PUB
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic init;
    logic scan;
    logic step;
    logic div_init;
    logic div_run;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic clear_item;
    logic scan_last;
    logic bit_last;
    logic div_last;
  } status_t;
endpackage

[design/fbwm_ctrl.sv]
// Sequencer of the frame budget window monitor.
`include "frame_budget_window_monitor_macros.svh"
module fbwm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fbwm_pkg::status_t sts,
  output fbwm_pkg::cmd_t  cmd
);
  import fbwm_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_LOAD;
      S_LOAD:     state_next = sts.clear_item ? S_PUB : S_INIT;
      S_INIT:     state_next = S_SCAN;
      S_SCAN:     if (sts.scan_last) state_next = S_DRAIN;
      S_DRAIN:    state_next = S_STEP;
      S_STEP:     state_next = sts.bit_last ? S_DIV_INIT : S_SCAN;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV:      if (sts.div_last) state_next = S_PUB;
      S_PUB:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_LOAD:     cmd.load = 1'b1;
      S_INIT:     cmd.init = 1'b1;
      S_SCAN:     cmd.scan = 1'b1;
      S_DRAIN:    cmd = '0;
      S_STEP:     cmd.step = 1'b1;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_run = 1'b1;
      S_PUB:      cmd.publish = out_free;
      default:    cmd = '0;
    endcase
  end

  `FBWM_ASSERT(a_pub_free, clk, rst, cmd.publish |-> (!out_valid || out_ready))
  `FBWM_ASSERT_NEXT(a_take_load, clk, rst, cmd.take, state == S_LOAD)
  `FBWM_ASSERT(a_rise_pub, clk, rst, $rose(out_valid) |-> $past(state) == S_PUB)
endmodule

[design/fbwm_dpath.sv]
// Window store, counters, percentile select and mean divider.
module fbwm_dpath #(
  parameter int WINDOW_DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fbwm_pkg::cmd_t            cmd,
  output fbwm_pkg::status_t         sts,
  input  logic                      cfg_we,
  input  logic [fbwm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      clear,
  input  logic signed [23:0]        frame_time,
  input  logic signed [23:0]        render_time,
  input  logic signed [23:0]        sim_time,
  input  logic signed [23:0]        stream_time,
  input  logic [31:0]               alloc_bytes,
  output logic [7:0]                sample_count,
  output logic [22:0]               latest_frame,
  output logic [31:0]               hitch_total,
  output logic [31:0]               render_over,
  output logic [31:0]               sim_over,
  output logic [31:0]               stream_over,
  output logic [31:0]               alloc_over,
  output logic [22:0]               mean_frame,
  output logic [22:0]               p95_frame,
  output logic [1:0]                health,
  output logic [4:0]                warn_flags
);
  import fbwm_pkg::*;

  localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SW  = TW + FW;
  localparam int DCW = $clog2(SW + 1);
  localparam int MW  = FW + 12;

  // Configuration.
  logic [TW-1:0] target_frame, warning_level, critical_level;
  logic [TW-1:0] render_limit, sim_budget, stream_budget;
  logic [CW-1:0] alloc_budget;
  logic [TW-1:0] thr_target, thr_warn, thr_crit;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_frame   <= 23'd4267;
      warning_level  <= 23'd5120;
      critical_level <= 23'd8533;
      render_limit   <= 23'd2048;
      sim_budget     <= 23'd1536;
      stream_budget  <= 23'd512;
      alloc_budget   <= 32'd1048576;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET: target_frame   <= cfg_data[TW-1:0];
        CFG_WARN:   warning_level  <= cfg_data[TW-1:0];
        CFG_CRIT:   critical_level <= cfg_data[TW-1:0];
        CFG_RENDER: render_limit   <= cfg_data[TW-1:0];
        CFG_SIM:    sim_budget     <= cfg_data[TW-1:0];
        CFG_STREAM: stream_budget  <= cfg_data[TW-1:0];
        CFG_ALLOC:  alloc_budget   <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign thr_target = (target_frame > ONE_MS) ? target_frame : ONE_MS;
  assign thr_warn   = (warning_level > thr_target) ? warning_level : thr_target;
  assign thr_crit   = (critical_level > thr_warn) ? critical_level : thr_warn;

  // Captured item, negative times clamped to zero.
  logic          clear_r;
  logic [TW-1:0] lat_frame, lat_render, lat_sim, lat_stream;
  logic [CW-1:0] lat_alloc;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      clear_r    <= clear;
      lat_frame  <= frame_time[IW-1]  ? '0 : frame_time[TW-1:0];
      lat_render <= render_time[IW-1] ? '0 : render_time[TW-1:0];
      lat_sim    <= sim_time[IW-1]    ? '0 : sim_time[TW-1:0];
      lat_stream <= stream_time[IW-1] ? '0 : stream_time[TW-1:0];
      lat_alloc  <= alloc_bytes;
    end
  end

  logic over_hitch, over_render, over_sim, over_stream, over_alloc;
  assign over_hitch  = lat_frame > thr_crit;
  assign over_render = lat_render > render_limit;
  assign over_sim    = lat_sim > sim_budget;
  assign over_stream = lat_stream > stream_budget;
  assign over_alloc  = lat_alloc > alloc_budget;

  // Violation counters, saturating.
  logic [CW-1:0] cnt_hitch, cnt_render, cnt_sim, cnt_stream, cnt_alloc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_hitch <= '0; cnt_render <= '0; cnt_sim <= '0;
      cnt_stream <= '0; cnt_alloc <= '0;
    end else if (cmd.load) begin
      if (clear_r) begin
        cnt_hitch <= '0; cnt_render <= '0; cnt_sim <= '0;
        cnt_stream <= '0; cnt_alloc <= '0;
      end else begin
        if (over_hitch && cnt_hitch != '1) cnt_hitch <= cnt_hitch + 1'b1;
        if (over_render && cnt_render != '1) cnt_render <= cnt_render + 1'b1;
        if (over_sim && cnt_sim != '1) cnt_sim <= cnt_sim + 1'b1;
        if (over_stream && cnt_stream != '1) cnt_stream <= cnt_stream + 1'b1;
        if (over_alloc && cnt_alloc != '1) cnt_alloc <= cnt_alloc + 1'b1;
      end
    end
  end

  // Window bookkeeping and memory.
  logic [FW-1:0] fill;
  logic [AW-1:0] oldest;
  logic [AW:0]   wr_sum, wr_wrap;
  logic [AW-1:0] wr_addr;
  logic          full;

  assign full    = fill == FW'(WINDOW_DEPTH);
  assign wr_sum  = (AW+1)'(oldest) + (AW+1)'(fill);
  assign wr_wrap = (wr_sum >= (AW+1)'(WINDOW_DEPTH)) ? wr_sum - (AW+1)'(WINDOW_DEPTH) : wr_sum;
  assign wr_addr = full ? oldest : wr_wrap[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      oldest <= '0;
    end else if (cmd.load) begin
      if (clear_r) begin
        fill   <= '0;
        oldest <= '0;
      end else if (!full) begin
        fill <= fill + 1'b1;
      end else begin
        oldest <= (oldest == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest + 1'b1;
      end
    end
  end

  logic [TW-1:0] frame_window [WINDOW_DEPTH];
  logic [AW-1:0] scan_addr;
  logic [TW-1:0] rd_data;
  logic          rd_vld;

  always_ff @(posedge clk) begin
    if (cmd.load && !clear_r) frame_window[wr_addr] <= lat_frame;
    rd_data <= frame_window[scan_addr];
  end

  // Radix select of the percentile, one bit per pass over the window.
  logic [FW-1:0] k_rem, cnt_low;
  logic [BW-1:0] bit_idx;
  logic [TW-1:0] prefix, hi_mask;
  logic [SW-1:0] sum;
  logic [MW-1:0] twentieth;
  logic          match;

  assign twentieth = (MW'(fill) * MW'(RECIP_20)) >> RECIP_SH;
  assign hi_mask   = ~((TW'(2) << bit_idx) - TW'(1));
  assign match     = (((rd_data ^ prefix) & hi_mask) == '0) && !rd_data[bit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      // ceil(0.95 n) - 1 equals n - 1 - floor(n / 20).
      k_rem     <= fill - FW'(1) - FW'(twentieth);
      prefix    <= '0;
      bit_idx   <= BW'(TW - 1);
      sum       <= '0;
      cnt_low   <= '0;
      scan_addr <= '0;
    end else begin
      if (cmd.scan) scan_addr <= scan_addr + 1'b1;
      if (rd_vld) begin
        if (match) cnt_low <= cnt_low + 1'b1;
        if (bit_idx == BW'(TW - 1)) sum <= sum + SW'(rd_data);
      end
      if (cmd.step) begin
        if (k_rem >= cnt_low) begin
          prefix <= prefix | (TW'(1) << bit_idx);
          k_rem  <= k_rem - cnt_low;
        end
        bit_idx   <= bit_idx - 1'b1;
        cnt_low   <= '0;
        scan_addr <= '0;
      end
    end
  end

  // Restoring divider for the mean, one quotient bit per cycle.
  logic [SW-1:0]  quo;
  logic [FW-1:0]  rem;
  logic [FW:0]    trial;
  logic [DCW-1:0] div_cnt;
  logic           fits;

  assign trial = {rem, quo[SW-1]};
  assign fits  = trial >= {1'b0, fill};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo     <= sum;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_run) begin
      rem     <= fits ? FW'(trial - {1'b0, fill}) : FW'(trial);
      quo     <= {quo[SW-2:0], fits};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign sts.clear_item = clear_r;
  assign sts.scan_last  = FW'(scan_addr) == fill - FW'(1);
  assign sts.bit_last   = bit_idx == '0;
  assign sts.div_last   = div_cnt == DCW'(SW - 1);

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (clear_r) begin
        sample_count <= '0; latest_frame <= '0; hitch_total <= '0;
        render_over <= '0; sim_over <= '0; stream_over <= '0; alloc_over <= '0;
        mean_frame <= '0; p95_frame <= '0; health <= HEALTH_GOOD; warn_flags <= '0;
      end else begin
        sample_count <= 8'(fill);
        latest_frame <= lat_frame;
        hitch_total  <= cnt_hitch;
        render_over  <= cnt_render;
        sim_over     <= cnt_sim;
        stream_over  <= cnt_stream;
        alloc_over   <= cnt_alloc;
        mean_frame   <= quo[TW-1:0];
        p95_frame    <= prefix;
        if (over_hitch || prefix > thr_crit) health <= HEALTH_CRIT;
        else if (lat_frame > thr_warn || prefix > thr_warn) health <= HEALTH_WARN;
        else health <= HEALTH_GOOD;
        warn_flags <= {over_hitch, over_alloc, over_stream, over_sim, over_render};
      end
    end
  end
endmodule

[design/frame_budget_window_monitor.sv]
// Top level of the frame budget window monitor.
//
//   channel  signals                          direction
//   in       in_valid/in_ready + item fields  item in
//   out      out_valid/out_ready + snapshot   snapshot out
//   cfg      cfg_valid/cfg_ready, index, data register write
//
// A clear item goes from the load state straight to publishing a cleared snapshot.
// A recorded item is stored in the window of n frames, and the percentile is found by
// 23 passes over the window memory, one entry per cycle, each pass followed by a
// drain and a step state; a bit-serial restoring divider then forms the mean.
// Reset is synchronous and needs no clearing pass. A stalled output holds its
// snapshot while the next item is taken and worked on.
module frame_budget_window_monitor #(
  parameter int WINDOW_DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      clear,
  input  logic signed [23:0]        frame_time,
  input  logic signed [23:0]        render_time,
  input  logic signed [23:0]        sim_time,
  input  logic signed [23:0]        stream_time,
  input  logic [31:0]               alloc_bytes,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                sample_count,
  output logic [22:0]               latest_frame,
  output logic [31:0]               hitch_total,
  output logic [31:0]               render_over,
  output logic [31:0]               sim_over,
  output logic [31:0]               stream_over,
  output logic [31:0]               alloc_over,
  output logic [22:0]               mean_frame,
  output logic [22:0]               p95_frame,
  output logic [1:0]                health,
  output logic [4:0]                warn_flags,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fbwm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import fbwm_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  fbwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbwm_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .clear        (clear),
    .frame_time   (frame_time),
    .render_time  (render_time),
    .sim_time     (sim_time),
    .stream_time  (stream_time),
    .alloc_bytes  (alloc_bytes),
    .sample_count (sample_count),
    .latest_frame (latest_frame),
    .hitch_total  (hitch_total),
    .render_over  (render_over),
    .sim_over     (sim_over),
    .stream_over  (stream_over),
    .alloc_over   (alloc_over),
    .mean_frame   (mean_frame),
    .p95_frame    (p95_frame),
    .health       (health),
    .warn_flags   (warn_flags)
  );
endmodule
